// File: hdl/alffc_pkg.sv
package alffc_pkg;

  localparam int LINE_LENGTH = 32;

  // APB register map
  localparam int APB_ADDR_W = 3;
  localparam logic REG_STATION_ADDRESS  = 1'b0;
  localparam logic REG_CRC_CHECK_ENABLE = 1'b1;

  localparam logic [7:0]  STATION_RESET = 8'h00;
  localparam logic        CRC_EN_RESET  = 1'b1;

  // character codes
  localparam logic [7:0] CH_ETX    = 8'h03;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_AT     = 8'h40;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h8408;
  localparam logic [15:0] ADDR_BROADCAST = 16'h00FF;
  localparam logic [15:0] DIGIT_INVALID  = 16'hFFFF;

  typedef enum logic [2:0] {
    VERDICT_OK_NO_CRC     = 3'd0,
    VERDICT_OK_CRC        = 3'd1,
    VERDICT_CRC_MISMATCH  = 3'd2,
    VERDICT_ADDR_MISMATCH = 3'd3,
    VERDICT_NO_ADDR       = 3'd4,
    VERDICT_RESPONSE      = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    PARSE_SP1,
    PARSE_DIGITS,
    PARSE_SP2,
    PARSE_BODY
  } parse_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_JUDGE,
    ST_SCAN_RD,
    ST_SCAN_EX,
    ST_CHECK,
    ST_EMIT_RD,
    ST_EMIT_EX,
    ST_VERDICT
  } ctrl_state_t;

  typedef struct packed {
    logic     accept;
    logic     init_scan;
    logic     scan_read;
    logic     scan_step;
    logic     start_emit;
    logic     emit_read;
    logic     emit_load;
    logic     set_verdict;
    verdict_t verdict;
    logic     load_verdict;
    logic     inc_no_addr;
    logic     inc_crc_err;
  } dp_cmd_t;

  typedef struct packed {
    logic eol;
    logic line_valid;
    logic first_star;
    logic first_at;
    logic station_set;
    logic scan_end;
    logic scan_fail;
    logic end_fail;
    logic crc_bad;
    logic emit_end;
    logic out_free;
  } dp_status_t;

endpackage

// File: hdl/alffc_in_if.sv
interface alffc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hdl/alffc_out_if.sv
interface alffc_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  verdict;
  logic        last_item;
  logic [15:0] overflow_count;
  logic [15:0] illegal_count;
  logic [15:0] crc_error_count;
  logic [15:0] missing_address_count;

  modport source (
    output valid, output item_kind, output payload_byte, output verdict,
    output last_item, output overflow_count, output illegal_count,
    output crc_error_count, output missing_address_count,
    input ready
  );
  modport sink (
    input valid, input item_kind, input payload_byte, input verdict,
    input last_item, input overflow_count, input illegal_count,
    input crc_error_count, input missing_address_count,
    output ready
  );
endinterface

// File: hdl/ascii_line_frame_filter_crc.sv
// A byte that does not end a line is taken while idle; the block is ready again on the next
// cycle. A CR or LF ending a non-empty line starts a judgement: unless the line is a
// response or, with a station set, has no address, the line store is scanned and, if the
// checks pass, the body is read out; no byte is taken until the verdict is loaded for output.
// One byte per cycle between line ends; each result byte is read from the store, then loaded.
// Reset (rst, synchronous): clears fill count, tallies, output valid and the controller;
// station_address goes to 0, crc_check_enable to 1; the line store is not cleared.
module ascii_line_frame_filter_crc #(
  parameter int LINE_LENGTH = alffc_pkg::LINE_LENGTH
) (
  input  logic                             clk,
  input  logic                             rst,
  alffc_in_if.sink                         bytes,
  alffc_out_if.source                      items,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [alffc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic [7:0] station_address;
  logic       crc_check_enable;
  logic       reg_sel;

  alffc_pkg::dp_cmd_t    cmd;
  alffc_pkg::dp_status_t status;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address  <= alffc_pkg::STATION_RESET;
      crc_check_enable <= alffc_pkg::CRC_EN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        alffc_pkg::REG_STATION_ADDRESS:  station_address  <= pwdata[7:0];
        alffc_pkg::REG_CRC_CHECK_ENABLE: crc_check_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      alffc_pkg::REG_STATION_ADDRESS:  prdata = {24'h000000, station_address};
      alffc_pkg::REG_CRC_CHECK_ENABLE: prdata = {31'h00000000, crc_check_enable};
      default:                         prdata = '0;
    endcase
  end

  alffc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bytes.valid),
    .in_ready (bytes.ready),
    .status   (status),
    .cmd      (cmd)
  );

  alffc_dp #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_dp (
    .clk                       (clk),
    .rst                       (rst),
    .rx_byte                   (bytes.rx_byte),
    .station_address           (station_address),
    .crc_check_enable          (crc_check_enable),
    .cmd                       (cmd),
    .status                    (status),
    .out_ready                 (items.ready),
    .out_valid                 (items.valid),
    .out_item_kind             (items.item_kind),
    .out_payload_byte          (items.payload_byte),
    .out_verdict               (items.verdict),
    .out_last_item             (items.last_item),
    .out_overflow_count        (items.overflow_count),
    .out_illegal_count         (items.illegal_count),
    .out_crc_error_count       (items.crc_error_count),
    .out_missing_address_count (items.missing_address_count)
  );

endmodule

// File: hdl/alffc_ctrl.sv
module alffc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  alffc_pkg::dp_status_t status,
  output alffc_pkg::dp_cmd_t    cmd
);

  alffc_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alffc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      alffc_pkg::ST_IDLE: begin
        if (in_valid && status.eol && status.line_valid) begin
          state_next = alffc_pkg::ST_JUDGE;
        end
      end
      alffc_pkg::ST_JUDGE: begin
        if (status.first_star || (!status.first_at && status.station_set)) begin
          state_next = alffc_pkg::ST_VERDICT;
        end else begin
          state_next = alffc_pkg::ST_SCAN_RD;
        end
      end
      alffc_pkg::ST_SCAN_RD: begin
        state_next = status.scan_end ? alffc_pkg::ST_CHECK : alffc_pkg::ST_SCAN_EX;
      end
      alffc_pkg::ST_SCAN_EX: begin
        state_next = status.scan_fail ? alffc_pkg::ST_VERDICT : alffc_pkg::ST_SCAN_RD;
      end
      alffc_pkg::ST_CHECK: begin
        if (status.end_fail || status.crc_bad) begin
          state_next = alffc_pkg::ST_VERDICT;
        end else begin
          state_next = alffc_pkg::ST_EMIT_RD;
        end
      end
      alffc_pkg::ST_EMIT_RD: begin
        state_next = status.emit_end ? alffc_pkg::ST_VERDICT : alffc_pkg::ST_EMIT_EX;
      end
      alffc_pkg::ST_EMIT_EX: begin
        if (status.out_free) begin
          state_next = alffc_pkg::ST_EMIT_RD;
        end
      end
      alffc_pkg::ST_VERDICT: begin
        if (status.out_free) begin
          state_next = alffc_pkg::ST_IDLE;
        end
      end
      default: state_next = alffc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.verdict = alffc_pkg::VERDICT_OK_NO_CRC;
    unique case (state)
      alffc_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      alffc_pkg::ST_JUDGE: begin
        if (status.first_star) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = alffc_pkg::VERDICT_RESPONSE;
        end else if (!status.first_at && status.station_set) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = alffc_pkg::VERDICT_NO_ADDR;
          cmd.inc_no_addr = 1'b1;
        end else begin
          cmd.init_scan = 1'b1;
        end
      end
      alffc_pkg::ST_SCAN_RD: begin
        cmd.scan_read = !status.scan_end;
      end
      alffc_pkg::ST_SCAN_EX: begin
        cmd.scan_step = 1'b1;
        if (status.scan_fail) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = alffc_pkg::VERDICT_ADDR_MISMATCH;
        end
      end
      alffc_pkg::ST_CHECK: begin
        if (status.end_fail) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = alffc_pkg::VERDICT_ADDR_MISMATCH;
        end else if (status.crc_bad) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = alffc_pkg::VERDICT_CRC_MISMATCH;
          cmd.inc_crc_err = 1'b1;
        end else begin
          cmd.start_emit = 1'b1;
        end
      end
      alffc_pkg::ST_EMIT_RD: begin
        cmd.emit_read = !status.emit_end;
      end
      alffc_pkg::ST_EMIT_EX: begin
        cmd.emit_load = status.out_free;
      end
      alffc_pkg::ST_VERDICT: begin
        cmd.load_verdict = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/alffc_dp.sv
module alffc_dp #(
  parameter int LINE_LENGTH = alffc_pkg::LINE_LENGTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            station_address,
  input  logic                  crc_check_enable,
  input  alffc_pkg::dp_cmd_t    cmd,
  output alffc_pkg::dp_status_t status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_item_kind,
  output logic [7:0]            out_payload_byte,
  output logic [2:0]            out_verdict,
  output logic                  out_last_item,
  output logic [15:0]           out_overflow_count,
  output logic [15:0]           out_illegal_count,
  output logic [15:0]           out_crc_error_count,
  output logic [15:0]           out_missing_address_count
);

  localparam int CNT_W  = $clog2(LINE_LENGTH + 1);
  localparam int ADDR_W = $clog2(LINE_LENGTH);

  function automatic logic [15:0] crc_add(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ alffc_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // {valid, value} for an uppercase hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= "0" && c <= "9") begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (c >= "A" && c <= "F") begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  logic [7:0]  line_store [LINE_LENGTH];
  logic [7:0]  rdata;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] line_end;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] body_end;
  logic [7:0]  first_byte;
  alffc_pkg::parse_mode_t mode;
  logic [15:0] addr_acc;
  logic [15:0] crc;
  logic [15:0] expected;
  logic        has_crc;
  alffc_pkg::verdict_t verdict_reg;
  logic [15:0] overflow_tally;
  logic [15:0] illegal_tally;
  logic [15:0] crc_error_tally;
  logic [15:0] no_address_tally;

  // incoming byte classification
  logic             overflow;
  logic [CNT_W-1:0] fill_eff;
  logic             is_eol;
  logic             is_etx;
  logic             is_printable;
  logic             do_append;

  assign overflow     = fill_count >= CNT_W'(LINE_LENGTH);
  assign fill_eff     = overflow ? '0 : fill_count;
  assign is_eol       = (rx_byte == alffc_pkg::CH_CR) || (rx_byte == alffc_pkg::CH_LF);
  assign is_etx       = rx_byte == alffc_pkg::CH_ETX;
  assign is_printable = !rx_byte[7] && (rx_byte >= alffc_pkg::CH_SPACE);
  assign do_append    = is_printable &&
                        ((fill_eff == '0) || (first_byte != alffc_pkg::CH_STAR));

  // per-byte parse step on the stored byte in rdata
  logic [4:0]  hex;
  logic        addr_ok;
  logic        step_fail;
  logic        step_body;
  alffc_pkg::parse_mode_t mode_s;
  logic [15:0] addr_s;
  logic [CNT_W-1:0] pos_s;
  logic [CNT_W-1:0] body_end_s;
  logic [15:0] crc_s;
  logic [15:0] expected_s;
  logic        has_crc_s;

  assign hex     = hex_decode(rdata);
  assign addr_ok = (addr_acc == {8'h00, station_address}) ||
                   (addr_acc == alffc_pkg::ADDR_BROADCAST);

  always_comb begin
    mode_s     = mode;
    addr_s     = addr_acc;
    pos_s      = pos;
    body_end_s = body_end;
    crc_s      = crc;
    expected_s = expected;
    has_crc_s  = has_crc;
    step_fail  = 1'b0;
    step_body  = 1'b0;
    unique case (mode)
      alffc_pkg::PARSE_SP1: begin
        if (rdata != alffc_pkg::CH_SPACE) begin
          if (hex[4]) begin
            addr_s = {12'h000, hex[3:0]};
            mode_s = alffc_pkg::PARSE_DIGITS;
          end else begin
            step_fail = 1'b1;
          end
        end
      end
      alffc_pkg::PARSE_DIGITS: begin
        if (hex[4]) begin
          addr_s = {addr_acc[11:0], hex[3:0]};
        end else if (!addr_ok) begin
          step_fail = 1'b1;
        end else if (rdata == alffc_pkg::CH_SPACE) begin
          mode_s = alffc_pkg::PARSE_SP2;
        end else begin
          mode_s    = alffc_pkg::PARSE_BODY;
          pos_s     = idx;
          step_body = 1'b1;
        end
      end
      alffc_pkg::PARSE_SP2: begin
        if (rdata != alffc_pkg::CH_SPACE) begin
          mode_s    = alffc_pkg::PARSE_BODY;
          pos_s     = idx;
          step_body = 1'b1;
        end
      end
      alffc_pkg::PARSE_BODY: step_body = 1'b1;
      default: ;
    endcase
    if (step_body && crc_check_enable) begin
      if (rdata == alffc_pkg::CH_DOLLAR) begin
        if (!has_crc) begin
          body_end_s = idx;
        end
        has_crc_s = 1'b1;
      end else if (has_crc) begin
        expected_s = hex[4] ? {expected[11:0], hex[3:0]} : alffc_pkg::DIGIT_INVALID;
      end else begin
        crc_s = crc_add(crc, rdata);
      end
    end
  end

  assign status.eol         = is_eol;
  assign status.line_valid  = fill_eff != '0;
  assign status.first_star  = first_byte == alffc_pkg::CH_STAR;
  assign status.first_at    = first_byte == alffc_pkg::CH_AT;
  assign status.station_set = station_address != 8'h00;
  assign status.scan_end    = idx == line_end;
  assign status.scan_fail   = step_fail;
  assign status.end_fail    = (mode == alffc_pkg::PARSE_SP1) ||
                              ((mode == alffc_pkg::PARSE_DIGITS) && !addr_ok);
  assign status.crc_bad     = has_crc && (expected != crc);
  assign status.emit_end    = idx == body_end;
  assign status.out_free    = !out_valid || out_ready;

  // line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && do_append) begin
      line_store[fill_eff[ADDR_W-1:0]] <= rx_byte;
    end
    if (cmd.scan_read || cmd.emit_read) begin
      rdata <= line_store[idx[ADDR_W-1:0]];
    end
  end

  // fill count and tallies
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count       <= '0;
      overflow_tally   <= '0;
      illegal_tally    <= '0;
      crc_error_tally  <= '0;
      no_address_tally <= '0;
    end else begin
      if (cmd.accept) begin
        if (overflow) begin
          overflow_tally <= overflow_tally + 16'd1;
        end
        if (is_eol || is_etx) begin
          fill_count <= '0;
        end else if (!is_printable) begin
          illegal_tally <= illegal_tally + 16'd1;
          fill_count    <= fill_eff;
        end else if (do_append) begin
          fill_count <= fill_eff + 1'b1;
        end else begin
          fill_count <= fill_eff;
        end
      end
      if (cmd.inc_no_addr) begin
        no_address_tally <= no_address_tally + 16'd1;
      end
      if (cmd.inc_crc_err) begin
        crc_error_tally <= crc_error_tally + 16'd1;
      end
    end
  end

  // line capture and parse registers
  always_ff @(posedge clk) begin
    if (cmd.accept && do_append && (fill_eff == '0)) begin
      first_byte <= rx_byte;
    end
    if (cmd.accept && is_eol) begin
      line_end <= fill_eff;
    end
    if (cmd.init_scan) begin
      idx      <= status.first_at ? CNT_W'(1) : '0;
      mode     <= status.first_at ? alffc_pkg::PARSE_SP1 : alffc_pkg::PARSE_BODY;
      pos      <= '0;
      body_end <= line_end;
      addr_acc <= '0;
      crc      <= alffc_pkg::CRC_INIT;
      expected <= '0;
      has_crc  <= 1'b0;
    end
    if (cmd.scan_step) begin
      idx      <= idx + 1'b1;
      mode     <= mode_s;
      pos      <= pos_s;
      body_end <= body_end_s;
      addr_acc <= addr_s;
      crc      <= crc_s;
      expected <= expected_s;
      has_crc  <= has_crc_s;
    end
    if (cmd.start_emit) begin
      // address ran to the end of the line: nothing left to emit
      idx         <= (mode == alffc_pkg::PARSE_BODY) ? pos : line_end;
      verdict_reg <= has_crc ? alffc_pkg::VERDICT_OK_CRC : alffc_pkg::VERDICT_OK_NO_CRC;
    end
    if (cmd.emit_load) begin
      idx <= idx + 1'b1;
    end
    if (cmd.set_verdict) begin
      verdict_reg <= cmd.verdict;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load || cmd.load_verdict) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load || cmd.load_verdict) begin
      out_item_kind             <= cmd.load_verdict;
      out_last_item             <= cmd.load_verdict;
      out_payload_byte          <= cmd.load_verdict ? 8'h00 : rdata;
      out_verdict               <= cmd.load_verdict ? verdict_reg : alffc_pkg::VERDICT_OK_NO_CRC;
      out_overflow_count        <= overflow_tally;
      out_illegal_count         <= illegal_tally;
      out_crc_error_count       <= crc_error_tally;
      out_missing_address_count <= no_address_tally;
    end
  end

endmodule

// File: hdl/alffc_checker.sv
module alffc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_item_kind,
  input logic [7:0] out_payload_byte,
  input logic [2:0] out_verdict,
  input logic       out_last_item
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item_kind) &&
      $stable(out_payload_byte) && $stable(out_verdict))
    else $error("stalled result changed");

  // command bytes carry no verdict; verdicts carry no byte and close the run
  a_item_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last_item == out_item_kind) &&
      (out_item_kind || out_verdict == alffc_pkg::VERDICT_OK_NO_CRC) &&
      (!out_item_kind || out_payload_byte == 8'h00))
    else $error("malformed result item");

  // a pending command byte means its verdict is still to come
  a_no_input_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item_kind |-> !in_ready)
    else $error("input taken before run finished");

endmodule

bind ascii_line_frame_filter_crc alffc_checker u_alffc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (bytes.ready),
  .out_valid        (items.valid),
  .out_ready        (items.ready),
  .out_item_kind    (items.item_kind),
  .out_payload_byte (items.payload_byte),
  .out_verdict      (items.verdict),
  .out_last_item    (items.last_item)
);
